// ----- sv/sbp_pkg.sv -----
package sbp_pkg;

    // Store geometry: one entry per channel and bin.
    localparam int MAX_BINS    = 4096;
    localparam int CHANNELS    = 2;
    localparam int BIN_W       = 12;
    localparam int STORE_DEPTH = CHANNELS * MAX_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Queue between front and back, and the result buffer at the output.
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int OF_DEPTH = 32;
    localparam int OF_PTR_W = $clog2(OF_DEPTH);

    // Square root and log pipelines.
    localparam int SQRT_STEPS = 32;
    localparam int LOG_STEPS  = 16;

    // 20*log10(2) in Q3.16 applied to a Q5.16 log2, and the 2^24 offset of Q8.24.
    localparam logic [18:0] LOG_K   = 19'd394566;
    localparam logic [40:0] LOG_OFF = 41'd1572864 * 41'd394566;
    localparam logic [40:0] LOG_RND = 41'd8388608;

    typedef enum logic [2:0] {
        CFG_FFT_SIZE_LOG2    = 3'd0,
        CFG_GRAVITY          = 3'd1,
        CFG_SMOOTHING_ENABLE = 3'd2,
        CFG_FAST_PEAKS       = 3'd3,
        CFG_SLOPE_ENABLE     = 3'd4,
        CFG_ROLLOFF_ENABLE   = 3'd5,
        CFG_DB_FLOOR         = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]         fft_size_log2;
        logic [15:0]        gravity;
        logic               smoothing_enable;
        logic               fast_peaks;
        logic               slope_enable;
        logic               rolloff_enable;
        logic signed [15:0] db_floor;
    } t_cfg;

    typedef struct packed {
        logic             chan;
        logic [BIN_W-1:0] bin;
        logic [23:0]      slope;
        logic [14:0]      roll;
    } t_side;

    typedef struct packed {
        logic [31:0]      mag;
        logic             chan;
        logic [BIN_W-1:0] bin;
        logic [14:0]      roll;
    } t_qitem;

    typedef struct packed {
        logic signed [15:0] level;
        logic               chan;
        logic [BIN_W-1:0]   bin;
    } t_res;

endpackage

// ----- sv/sbp_front.sv -----
module sbp_front
    import sbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_block,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_bin_real,
    input  logic signed [31:0] i_bin_imag,
    input  logic               i_chan,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic [23:0]        i_slope_gain,
    input  logic [14:0]        i_rolloff_db,
    input  logic               i_q_full,
    output logic               o_push,
    output t_qitem             o_item
);

    localparam int ST_SQRT  = 3;
    localparam int ST_SCALE = ST_SQRT + SQRT_STEPS;
    localparam int ST_SLOPE = ST_SCALE + 1;
    localparam int NST      = ST_SLOPE + 1;

    logic        w_adv;
    logic [31:0] w_re;
    logic [31:0] w_im;
    logic [31:0] w_abs_re;
    logic [31:0] w_abs_im;

    logic [NST-1:0] r_v;
    t_side          r_sd   [NST];
    logic [31:0]    r_a;
    logic [31:0]    r_b;
    logic [63:0]    r_aa;
    logic [63:0]    r_bb;
    logic [63:0]    r_sum;
    logic [63:0]    r_rem  [SQRT_STEPS];
    logic [31:0]    r_root [SQRT_STEPS];
    logic [31:0]    r_scl;
    logic [31:0]    r_mag;

    logic [40:0] w_shift;
    logic [55:0] w_prod;

    // The pipeline moves as a whole; it holds only when its last item cannot enter the queue.
    assign w_adv   = !r_v[NST-1] || !i_q_full;
    assign o_ready = w_adv && !i_block;

    assign w_re     = i_bin_real;
    assign w_im     = i_bin_imag;
    assign w_abs_re = w_re[31] ? (~w_re + 32'd1) : w_re;
    assign w_abs_im = w_im[31] ? (~w_im + 32'd1) : w_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NST-2:0], i_valid && o_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= '{chan: i_chan, bin: i_bin_index, slope: i_slope_gain,
                         roll: i_rolloff_db};
            for (int k = 1; k < NST; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_a   <= w_abs_re;
            r_b   <= w_abs_im;
            r_aa  <= {32'd0, r_a} * {32'd0, r_a};
            r_bb  <= {32'd0, r_b} * {32'd0, r_b};
            r_sum <= r_aa + r_bb;
        end
    end

    // One root bit per stage, most significant first; the remainder tracks v - root^2.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [63:0] w_rem_in;
        logic [31:0] w_root_in;
        logic [63:0] w_trial;
        if (k == 0) begin : g_first
            assign w_rem_in  = r_sum;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end
        assign w_trial = ({32'd0, w_root_in} << (SQRT_STEPS - k))
                       + (64'd1 << (2 * (SQRT_STEPS - 1 - k)));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_rem_in >= w_trial) begin
                    r_rem[k]  <= w_rem_in - w_trial;
                    r_root[k] <= w_root_in | (32'd1 << (SQRT_STEPS - 1 - k));
                end else begin
                    r_rem[k]  <= w_rem_in;
                    r_root[k] <= w_root_in;
                end
            end
        end
    end

    assign w_shift = {r_root[SQRT_STEPS-1], 9'd0} >> i_cfg.fft_size_log2;
    assign w_prod  = {24'd0, r_scl} * {32'd0, r_sd[ST_SCALE].slope};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_scl <= (w_shift[40:32] != '0) ? 32'hFFFF_FFFF : w_shift[31:0];
            if (!i_cfg.slope_enable) begin
                r_mag <= r_scl;
            end else if (w_prod[55:48] != '0) begin
                r_mag <= 32'hFFFF_FFFF;
            end else begin
                r_mag <= w_prod[47:16];
            end
        end
    end

    assign o_push = r_v[NST-1] && w_adv;
    assign o_item = '{mag: r_mag, chan: r_sd[ST_SLOPE].chan, bin: r_sd[ST_SLOPE].bin,
                      roll: r_sd[ST_SLOPE].roll};

endmodule

// ----- sv/sbp_queue.sv -----
module sbp_queue
    import sbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    input  logic   i_pop,
    output logic   o_empty,
    output logic   o_full,
    output t_qitem o_item
);

    t_qitem             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- sv/sbp_back.sv -----
module sbp_back
    import sbp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_empty,
    input  t_qitem              i_q_item,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_level_db,
    output logic                o_out_chan,
    output logic [BIN_W-1:0]    o_out_bin
);

    logic [31:0]       r_store [STORE_DEPTH];
    logic [31:0]       r_rd;
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [OF_PTR_W:0] r_credit;

    // Stage A: smoothing.  Stage B: smoothed magnitude.  Stage C: normalized.
    logic              r_a_v;
    t_qitem            r_a_it;
    logic              r_b_v;
    logic              r_b_wr;
    logic [ADDR_W-1:0] r_b_addr;
    t_qitem            r_b_it;
    logic              r_c_v;
    logic [31:0]       r_c_y;
    logic [4:0]        r_c_p;
    logic              r_c_zero;
    t_qitem            r_c_it;

    logic [LOG_STEPS-1:0] r_l_v;
    logic [31:0]          r_l_y    [LOG_STEPS];
    logic [15:0]          r_l_fr   [LOG_STEPS];
    logic [4:0]           r_l_p    [LOG_STEPS];
    logic                 r_l_zero [LOG_STEPS];
    t_qitem               r_l_it   [LOG_STEPS];

    logic               r_d_v;
    logic signed [17:0] r_d_lvl;
    logic               r_d_zero;
    t_qitem             r_d_it;

    t_res               r_of [OF_DEPTH];
    logic [OF_PTR_W-1:0] r_wp;
    logic [OF_PTR_W-1:0] r_rp;
    logic [OF_PTR_W:0]   r_ocnt;

    logic              w_out_acc;
    logic [ADDR_W-1:0] w_q_addr;
    logic [ADDR_W-1:0] w_a_addr;
    logic [31:0]       w_old;
    logic [31:0]       w_oldp;
    logic signed [32:0] w_diff;
    logic signed [49:0] w_prod;
    logic signed [49:0] w_rnd;
    logic signed [33:0] w_new;
    logic [31:0]       w_smooth;
    logic [4:0]        w_p;
    logic [20:0]       w_l;
    logic [40:0]       w_u;
    logic signed [41:0] w_dlt;
    logic signed [17:0] w_lvl;
    logic signed [17:0] w_floor;
    t_res              w_res;

    assign w_out_acc  = o_valid && i_ready;
    assign o_clearing = r_clr;
    assign o_pop      = !i_q_empty && !r_clr && (r_credit != (OF_PTR_W+1)'(OF_DEPTH));

    assign w_q_addr = {i_q_item.chan, i_q_item.bin};
    assign w_a_addr = {r_a_it.chan, r_a_it.bin};

    // Credits cover everything popped but not yet delivered, so the buffer never overflows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + (OF_PTR_W+1)'(o_pop) - (OF_PTR_W+1)'(w_out_acc);
        end
    end

    // Smoothing: new = mag + gravity*(old - mag) / 2^16, rounded.
    assign w_old  = (r_b_v && r_b_wr && (r_b_addr == w_a_addr)) ? r_b_it.mag : r_rd;
    assign w_oldp = (i_cfg.fast_peaks && (r_a_it.mag > w_old)) ? r_a_it.mag : w_old;
    assign w_diff = $signed({1'b0, w_oldp}) - $signed({1'b0, r_a_it.mag});
    assign w_prod = $signed({1'b0, i_cfg.gravity}) * w_diff;
    assign w_rnd  = w_prod + 50'sd32768;
    assign w_new  = w_rnd[49:16] + $signed({2'b00, r_a_it.mag});
    assign w_smooth = i_cfg.smoothing_enable ? w_new[31:0] : r_a_it.mag;

    always_ff @(posedge i_clk) begin
        r_rd <= r_store[w_q_addr];
        if (r_clr) begin
            r_store[r_clr_addr] <= '0;
        end else if (r_a_v && i_cfg.smoothing_enable) begin
            r_store[w_a_addr] <= w_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_comb begin
        w_p = '0;
        for (int k = 0; k < 32; k++) begin
            if (r_b_it.mag[k]) begin
                w_p = 5'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= o_pop;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_it     <= i_q_item;
        r_b_it     <= '{mag: w_smooth, chan: r_a_it.chan, bin: r_a_it.bin,
                        roll: r_a_it.roll};
        r_b_wr     <= i_cfg.smoothing_enable;
        r_b_addr   <= w_a_addr;
        r_c_y      <= r_b_it.mag << (5'd31 - w_p);
        r_c_p      <= w_p;
        r_c_zero   <= (r_b_it.mag == '0);
        r_c_it     <= r_b_it;
    end

    // Log2 fraction, one bit per stage by squaring the normalized mantissa.
    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
        logic [31:0] w_y_in;
        logic [15:0] w_fr_in;
        logic [63:0] w_sq;
        logic [32:0] w_t;
        if (k == 0) begin : g_first
            assign w_y_in  = r_c_y;
            assign w_fr_in = '0;
            always_ff @(posedge i_clk) begin
                r_l_p[k]    <= r_c_p;
                r_l_zero[k] <= r_c_zero;
                r_l_it[k]   <= r_c_it;
            end
        end else begin : g_next
            assign w_y_in  = r_l_y[k-1];
            assign w_fr_in = r_l_fr[k-1];
            always_ff @(posedge i_clk) begin
                r_l_p[k]    <= r_l_p[k-1];
                r_l_zero[k] <= r_l_zero[k-1];
                r_l_it[k]   <= r_l_it[k-1];
            end
        end
        assign w_sq = {32'd0, w_y_in} * {32'd0, w_y_in};
        assign w_t  = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            r_l_y[k]  <= w_t[32] ? w_t[32:1] : w_t[31:0];
            r_l_fr[k] <= {w_fr_in[14:0], w_t[32]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= '0;
            r_d_v <= 1'b0;
        end else begin
            r_l_v <= {r_l_v[LOG_STEPS-2:0], r_c_v};
            r_d_v <= r_l_v[LOG_STEPS-1];
        end
    end

    assign w_l   = {r_l_p[LOG_STEPS-1], r_l_fr[LOG_STEPS-1]};
    assign w_u   = {20'd0, w_l} * {22'd0, LOG_K} + LOG_RND;
    assign w_dlt = $signed({1'b0, w_u}) - $signed({1'b0, LOG_OFF});

    always_ff @(posedge i_clk) begin
        r_d_lvl  <= w_dlt[41:24];
        r_d_zero <= r_l_zero[LOG_STEPS-1];
        r_d_it   <= r_l_it[LOG_STEPS-1];
    end

    assign w_floor = 18'(i_cfg.db_floor);

    always_comb begin
        w_lvl = r_d_lvl;
        if (i_cfg.rolloff_enable && (r_d_it.bin != '0)) begin
            w_lvl = r_d_lvl - $signed({3'b000, r_d_it.roll});
        end
        if (r_d_zero || (w_lvl < w_floor)) begin
            w_lvl = w_floor;
        end
        w_res = '{level: w_lvl[15:0], chan: r_d_it.chan, bin: r_d_it.bin};
    end

    // Result buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_d_v) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_out_acc) begin
                r_rp <= r_rp + 1'b1;
            end
            r_ocnt <= r_ocnt + (OF_PTR_W+1)'(r_d_v) - (OF_PTR_W+1)'(w_out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d_v) begin
            r_of[r_wp] <= w_res;
        end
    end

    assign o_valid    = (r_ocnt != '0);
    assign o_level_db = r_of[r_rp].level;
    assign o_out_chan = r_of[r_rp].chan;
    assign o_out_bin  = r_of[r_rp].bin;

endmodule

// ----- sv/spectrum_bin_postprocess.sv -----
// Spectrum bin post-processing: turns one transform bin per request into a level in dBFS.
// Input channel (i_valid / o_ready) carries real and imaginary parts, channel, bin number,
// slope gain and roll-off. Output channel (o_valid / i_ready) returns level_db, channel
// and bin, one result per request, in request order.
// Configuration is written through i_cfg_valid / o_cfg_ready with a register index and
// 16 bits of data; o_cfg_ready is always high. Write only while the block is idle.
// Throughput is one request per cycle when nothing stalls. The front end computes the
// magnitude with a 32-stage square root pipeline and scales it; a four-entry queue hands
// it to the back end, which smooths it against a 8192-entry store and takes the log over
// 16 squaring stages. Back-to-back requests to the same store entry are forwarded around
// the store. After reset the store is cleared one entry per cycle; o_ready is low until
// all 8192 entries are cleared, while configuration writes are still taken.
// When the receiver stalls, up to 32 results wait in the output buffer; once the buffer
// credits run out the back end stops drawing from the queue, the queue fills, and the
// front end then holds o_ready low until space frees up. Nothing is dropped.
module spectrum_bin_postprocess
    import sbp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_bin_real,
    input  logic signed [31:0]  i_bin_imag,
    input  logic                i_chan,
    input  logic [BIN_W-1:0]    i_bin_index,
    input  logic [23:0]         i_slope_gain,
    input  logic [14:0]         i_rolloff_db,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_level_db,
    output logic                o_out_chan,
    output logic [BIN_W-1:0]    o_out_bin
);

    t_cfg   r_cfg;
    logic   w_clearing;
    logic   w_push;
    logic   w_pop;
    logic   w_q_empty;
    logic   w_q_full;
    t_qitem w_push_item;
    t_qitem w_head_item;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes to unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fft_size_log2: 4'd12, gravity: 16'd0, smoothing_enable: 1'b0,
                       fast_peaks: 1'b0, slope_enable: 1'b0, rolloff_enable: 1'b0,
                       db_floor: -16'sd30720};
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FFT_SIZE_LOG2:    r_cfg.fft_size_log2    <= i_cfg_data[3:0];
                CFG_GRAVITY:          r_cfg.gravity          <= i_cfg_data;
                CFG_SMOOTHING_ENABLE: r_cfg.smoothing_enable <= i_cfg_data[0];
                CFG_FAST_PEAKS:       r_cfg.fast_peaks       <= i_cfg_data[0];
                CFG_SLOPE_ENABLE:     r_cfg.slope_enable     <= i_cfg_data[0];
                CFG_ROLLOFF_ENABLE:   r_cfg.rolloff_enable   <= i_cfg_data[0];
                CFG_DB_FLOOR:         r_cfg.db_floor         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_block      (w_clearing),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_bin_real   (i_bin_real),
        .i_bin_imag   (i_bin_imag),
        .i_chan       (i_chan),
        .i_bin_index  (i_bin_index),
        .i_slope_gain (i_slope_gain),
        .i_rolloff_db (i_rolloff_db),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    sbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_item  (w_head_item)
    );

    sbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_q_empty),
        .i_q_item   (w_head_item),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_level_db (o_level_db),
        .o_out_chan (o_out_chan),
        .o_out_bin  (o_out_bin)
    );

endmodule

// ----- bench/spectrum_bin_postprocess_tb.sv -----
`timescale 1ns / 1ps

// Bench for the spectrum bin post-processor. A short table of directed bins runs under the
// reset settings, then random bins run through several register settings. Every accepted
// request is pushed through a behavioral copy of the block (square root, 2/N scale, slope,
// smoothing store, log and floor), and each returned level is compared against it in order.
module spectrum_bin_postprocess_tb;
    import sbp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 100;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_bin_real = '0;
    logic signed [31:0] i_bin_imag = '0;
    logic               i_chan = 1'b0;
    logic [BIN_W-1:0]   i_bin_index = '0;
    logic [23:0]        i_slope_gain = '0;
    logic [14:0]        i_rolloff_db = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_level_db;
    logic               o_out_chan;
    logic [BIN_W-1:0]   o_out_bin;

    spectrum_bin_postprocess u_top (.*);

    always #2 i_clk = ~i_clk;

    // Model copy of the register file and the smoothing store.
    t_cfg        cfg_m;
    logic [31:0] smooth_m [STORE_DEPTH];
    t_res        level_q [$];
    int          errors = 0;
    int          cycles = 0;

    // Sender burst state.
    int burst_left = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("spectrum_bin_postprocess: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Integer square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // log2 of a nonzero value: integer part in the top bits, 16 fraction bits by squaring.
    function automatic logic [63:0] log2_fix(logic [31:0] x);
        int          p;
        logic [63:0] y;
        logic [63:0] frac;
        p = 31;
        frac = '0;
        while (x[p] == 1'b0) p--;
        y = 64'(x) << (31 - p);
        for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                y >>= 1;
            end
        end
        return (64'(p) << 16) | frac;
    endfunction

    // Works out the level of one bin and updates the smoothing store like the block does.
    function automatic t_res predict_bin(logic signed [31:0] re, logic signed [31:0] im,
                                         logic ch, logic [BIN_W-1:0] bin,
                                         logic [23:0] slope, logic [14:0] roll);
        logic [63:0] a, b, v, u, off, old;
        logic [31:0] mag;
        int          level;
        int          idx;
        t_res        r;
        a = re[31] ? 64'(-longint'(re)) : 64'(re);
        b = im[31] ? 64'(-longint'(im)) : 64'(im);
        v = (root64(a * a + b * b) << 9) >> cfg_m.fft_size_log2;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        if (cfg_m.slope_enable) begin
            v = (v * 64'(slope)) >> 16;
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        end
        mag = v[31:0];
        if (cfg_m.smoothing_enable) begin
            idx = int'(ch) * MAX_BINS + int'(bin);
            old = 64'(smooth_m[idx]);
            if (cfg_m.fast_peaks && 64'(mag) > old) old = 64'(mag);
            v = (64'(cfg_m.gravity) * old + (64'd65536 - 64'(cfg_m.gravity)) * 64'(mag)
                 + 64'd32768) >> 16;
            mag = v[31:0];
            smooth_m[idx] = mag;
        end
        if (mag == 0) begin
            level = int'(cfg_m.db_floor);
        end else begin
            u = log2_fix(mag) * 64'(LOG_K) + 64'd8388608;
            off = (64'd24 << 16) * 64'(LOG_K);
            if (u >= off) level = int'((u - off) >> 24);
            else level = -int'((off - u + 64'hFF_FFFF) >> 24);
            if (cfg_m.rolloff_enable && bin != 0) level -= int'(roll);
            if (level < int'(cfg_m.db_floor)) level = int'(cfg_m.db_floor);
        end
        r.level = level[15:0];
        r.chan = ch;
        r.bin = bin;
        return r;
    endfunction

    // Receiver: ready follows a stall pattern whose mode changes every so often,
    // from never stalling to stalling most of the time.
    int rx_mode = 0;
    int rx_left = 0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(5, 120);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Result checker: each accepted result against the oldest pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (level_q.size() == 0) begin
                report_mismatch("unexpected result, bin", int'(o_out_bin), -1);
            end else begin
                t_res want;
                want = level_q.pop_front();
                if (o_level_db !== want.level)
                    report_mismatch("level_db", int'(o_level_db), int'(want.level));
                if (o_out_chan !== want.chan)
                    report_mismatch("out_chan", int'(o_out_chan), int'(want.chan));
                if (o_out_bin !== want.bin)
                    report_mismatch("out_bin", int'(o_out_bin), int'(want.bin));
            end
        end
    end

    // One register write; called at a falling edge while the block is idle. Valid stays
    // high on return so that writes can follow back to back; the caller drops it.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FFT_SIZE_LOG2:    cfg_m.fft_size_log2 = data[3:0];
            CFG_GRAVITY:          cfg_m.gravity = data;
            CFG_SMOOTHING_ENABLE: cfg_m.smoothing_enable = data[0];
            CFG_FAST_PEAKS:       cfg_m.fast_peaks = data[0];
            CFG_SLOPE_ENABLE:     cfg_m.slope_enable = data[0];
            CFG_ROLLOFF_ENABLE:   cfg_m.rolloff_enable = data[0];
            CFG_DB_FLOOR:         cfg_m.db_floor = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // One bin request. Sends come in bursts; between most bursts valid drops for a while.
    // Returns the predicted result so the directed table can compare it with its own value.
    task automatic send_bin(logic signed [31:0] re, logic signed [31:0] im, logic ch,
                            logic [BIN_W-1:0] bin, logic [23:0] slope, logic [14:0] roll,
                            output t_res pred);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_bin_real <= re;
        i_bin_imag <= im;
        i_chan <= ch;
        i_bin_index <= bin;
        i_slope_gain <= slope;
        i_rolloff_db <= roll;
        do @(posedge i_clk); while (!o_ready);
        pred = predict_bin(re, im, ch, bin, slope, roll);
        level_q.push_back(pred);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has come back, then lets the
    // pipeline settle so that a register write cannot reach a request still in flight.
    task automatic drain;
        i_valid <= 1'b0;
        burst_left = 0;
        while (level_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Random component of a bin: often scaled down so the levels cover the whole dB range.
    function automatic logic signed [31:0] rand_part();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '0;
            3: v = v;
            default: v = 32'($signed(v) >>> $urandom_range(0, 31));
        endcase
        return v;
    endfunction

    task automatic random_bins(int count);
        t_res             pred;
        logic [BIN_W-1:0] bin;
        logic [23:0]      slope;
        logic [14:0]      roll;
        for (int n = 0; n < count; n++) begin
            // A handful of bins repeat so that smoothing keeps hitting the same entries,
            // back to back as well.
            bin = ($urandom_range(0, 3) != 0) ? BIN_W'($urandom_range(0, 5)) : BIN_W'($urandom());
            slope = ($urandom_range(0, 1) == 1) ? 24'($urandom())
                                                : 24'h01_0000 + 24'($urandom_range(0, 255));
            roll = ($urandom_range(0, 1) == 1) ? 15'($urandom()) : 15'($urandom_range(0, 2560));
            send_bin(rand_part(), rand_part(), 1'($urandom()), bin, slope, roll, pred);
        end
    endtask

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ch;
        logic [BIN_W-1:0]   bin;
        logic [23:0]        slope;
        logic [14:0]        roll;
        bit                 fixed;
        logic signed [15:0] level;
    } t_bin_row;

    // Directed rows under the reset settings. Rows with a fixed level: zero magnitude sits
    // at the default floor, a magnitude too small to survive the 2/N scale does too, and a
    // full-scale real or imaginary part gives 16.0 in Q8.24, which is 24.08 dB.
    t_bin_row dir_rows [] = '{
        '{32'sd0,          32'sd0,          1'b0, 12'd0,    24'd0,       15'd0,     1'b1, -16'sd30720},
        '{32'sd1,          32'sd0,          1'b0, 12'd1,    24'd0,       15'd0,     1'b1, -16'sd30720},
        '{32'sh8000_0000,  32'sd0,          1'b0, 12'd0,    24'h01_0000, 15'd0,     1'b1, 16'sd6165},
        '{32'sd0,          32'sh8000_0000,  1'b1, 12'd4095, 24'hFF_FFFF, 15'h7FFF,  1'b1, 16'sd6165},
        '{32'sh8000_0000,  32'sh8000_0000,  1'b1, 12'd4095, 24'hFF_FFFF, 15'h7FFF,  1'b0, 16'sd0},
        '{32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  1'b0, 12'd2048, 24'h00_0001, 15'h4000,  1'b0, 16'sd0},
        '{32'sh7FFF_FFFF,  32'sh8000_0000,  1'b1, 12'd1,    24'h80_0000, 15'd1,     1'b0, 16'sd0},
        '{-32'sd1,         32'sd0,          1'b0, 12'd7,    24'd0,       15'd0,     1'b0, 16'sd0},
        '{32'sh0001_0000,  32'sd0,          1'b0, 12'd100,  24'h01_0000, 15'd256,   1'b0, 16'sd0},
        '{32'sh0003_0000,  -32'sh0004_0000, 1'b1, 12'd100,  24'h02_0000, 15'd256,   1'b0, 16'sd0},
        '{32'sh5555_5555,  32'shAAAA_AAAA,  1'b0, 12'hAAA,  24'h55_5555, 15'h2AAA,  1'b0, 16'sd0},
        '{32'shAAAA_AAAA,  32'sh5555_5555,  1'b1, 12'h555,  24'hAA_AAAA, 15'h5555,  1'b0, 16'sd0},
        '{32'sh0000_0100,  32'sh0000_0100,  1'b0, 12'd3,    24'd12345,   15'd100,   1'b0, 16'sd0}
    };

    // Register settings per random phase: size, gravity, smoothing, fast peaks, slope,
    // roll-off, floor. It has both gravity extremes, the lowest floor and a size of 0.
    typedef struct {
        logic [15:0] size_log2;
        logic [15:0] grav;
        logic [15:0] smooth_en;
        logic [15:0] peaks_en;
        logic [15:0] slope_en;
        logic [15:0] roll_en;
        logic [15:0] floor_db;
    } t_phase;

    t_phase phases [] = '{
        '{16'd12, 16'h8000, 16'd1, 16'd0, 16'd0, 16'd0, 16'hA000},
        '{16'd4,  16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'h8000},
        '{16'd15, 16'h0000, 16'd0, 16'd0, 16'd1, 16'd1, 16'h0000},
        '{16'd9,  16'hF000, 16'd1, 16'd1, 16'd0, 16'd1, 16'hD8F0},
        '{16'd0,  16'd1234, 16'd1, 16'd0, 16'd1, 16'd0, 16'h0064},
        '{16'd13, 16'hC000, 16'd1, 16'd0, 16'd0, 16'd0, 16'hEC00}
    };

    initial begin
        t_res pred;
        cfg_m = '{fft_size_log2: 4'd12, gravity: 16'd0, smoothing_enable: 1'b0,
                  fast_peaks: 1'b0, slope_enable: 1'b0, rolloff_enable: 1'b0,
                  db_floor: -16'sd30720};
        foreach (smooth_m[k]) smooth_m[k] = '0;

        // Synchronous reset, released at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset settings; the store clear holds o_ready low first.
        foreach (dir_rows[k]) begin
            send_bin(dir_rows[k].re, dir_rows[k].im, dir_rows[k].ch, dir_rows[k].bin,
                     dir_rows[k].slope, dir_rows[k].roll, pred);
            if (dir_rows[k].fixed && pred.level !== dir_rows[k].level)
                report_mismatch("directed level", int'(pred.level), int'(dir_rows[k].level));
        end

        // Random phases. Draining between phases also makes the sender wait for every
        // outstanding result before it goes on.
        foreach (phases[k]) begin
            drain();
            write_reg(CFG_FFT_SIZE_LOG2, phases[k].size_log2);
            write_reg(CFG_GRAVITY, phases[k].grav);
            write_reg(CFG_SMOOTHING_ENABLE, phases[k].smooth_en);
            write_reg(CFG_FAST_PEAKS, phases[k].peaks_en);
            write_reg(CFG_SLOPE_ENABLE, phases[k].slope_en);
            write_reg(CFG_ROLLOFF_ENABLE, phases[k].roll_en);
            write_reg(CFG_DB_FLOOR, phases[k].floor_db);
            i_cfg_valid <= 1'b0;
            random_bins(180);
        end

        drain();
        if (errors == 0) begin
            $display("spectrum_bin_postprocess: match");
        end else begin
            $display("spectrum_bin_postprocess: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sbp_pkg.sv
sv/sbp_front.sv
sv/sbp_queue.sv
sv/sbp_back.sv
sv/spectrum_bin_postprocess.sv
bench/spectrum_bin_postprocess_tb.sv
